// ----- rtl/sts_pkg.sv -----
package sts_pkg;

    // Width of the limit registers and of the register data bus.
    localparam int CFG_W   = 12;
    localparam int APB_W   = 32;
    localparam int ADDR_W  = 3;

    // Register indexes, one 32-bit word each.
    localparam logic REG_STRING_LIMIT = 1'b0;
    localparam logic REG_SYMBOL_LIMIT = 1'b1;

    localparam logic [CFG_W-1:0] LIMIT_RESET = 12'd255;

    // Results held by one queue entry, and the queue depth.
    localparam int SLOTS       = 3;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [3:0] {
        K_OPEN    = 4'd0,
        K_CLOSE   = 4'd1,
        K_DOT     = 4'd2,
        K_QUOTE   = 4'd3,
        K_TRUE    = 4'd4,
        K_FALSE   = 4'd5,
        K_INT     = 4'd6,
        K_STRCHAR = 4'd7,
        K_STREND  = 4'd8,
        K_SYMCHAR = 4'd9,
        K_SYMEND  = 4'd10,
        K_EOF     = 4'd11,
        K_ERROR   = 4'd12
    } t_kind;

    // Error codes. Tokens other than errors carry the zero code.
    typedef enum logic [2:0] {
        E_INVALID    = 3'd0,
        E_STR_LONG   = 3'd1,
        E_SYM_LONG   = 3'd2,
        E_UNTERM     = 3'd3,
        E_CHAR_CONST = 3'd4
    } t_err;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  chr;
        t_err        err;
    } t_slot;

    typedef logic [1:0] t_count;

endpackage

// ----- rtl/sts_front.sv -----
module sts_front #(
    parameter int VALUE_WIDTH  = 32,
    parameter int LENGTH_WIDTH = 12
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic [7:0]                     i_byte,
    input  logic [sts_pkg::CFG_W-1:0]      i_string_limit,
    input  logic [sts_pkg::CFG_W-1:0]      i_symbol_limit,
    output logic                           o_enq,
    output sts_pkg::t_count                o_cnt,
    output sts_pkg::t_slot [2:0]           o_slots,
    output logic [VALUE_WIDTH-1:0]         o_val
);

    localparam int LEN_MAX = (1 << LENGTH_WIDTH) - 1;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DQUOT = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;

    localparam logic [4:0] BASE_8  = 5'd8;
    localparam logic [4:0] BASE_10 = 5'd10;
    localparam logic [4:0] BASE_16 = 5'd16;

    typedef logic [VALUE_WIDTH-1:0]  t_val;
    typedef logic [LENGTH_WIDTH-1:0] t_len;
    typedef logic [LENGTH_WIDTH:0]   t_lim;

    typedef enum logic [10:0] {
        M_IDLE     = 11'b000_0000_0001,
        M_COMMENT  = 11'b000_0000_0010,
        M_MINUS    = 11'b000_0000_0100,
        M_DOT      = 11'b000_0000_1000,
        M_HASH     = 11'b000_0001_0000,
        M_NUMSTART = 11'b000_0010_0000,
        M_NUM      = 11'b000_0100_0000,
        M_STRING   = 11'b000_1000_0000,
        M_STRESC   = 11'b001_0000_0000,
        M_SYMBOL   = 11'b010_0000_0000,
        M_ERROR    = 11'b100_0000_0000
    } t_mode;

    // Scanner state together with the results gathered for the current byte.
    typedef struct packed {
        t_mode                  mode;
        t_val                   acc;
        logic                   neg;
        logic [4:0]             base;
        t_len                   len;
        sts_pkg::t_count        cnt;
        sts_pkg::t_slot [2:0]   res;
        t_val                   val;
    } t_scan;

    t_mode      r_mode;
    t_val       r_acc;
    logic       r_neg;
    logic [4:0] r_base;
    t_len       r_len;

    t_scan      s_nxt;
    t_lim       str_lim;
    t_lim       sym_lim;

    function automatic logic f_is_space(logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
    endfunction

    function automatic logic f_is_digit(logic [7:0] b);
        return (b >= CH_0) && (b <= CH_9);
    endfunction

    function automatic logic f_is_alpha(logic [7:0] b);
        return ((b >= CH_LA) && (b <= CH_LZ)) || ((b >= CH_UA) && (b <= CH_UZ));
    endfunction

    function automatic logic f_is_sym_start(logic [7:0] b);
        return (b == "!") || (b == "@") || (b == "$") || (b == "%") || (b == "^") ||
               (b == "&") || (b == "*") || (b == "_") || (b == "=") || (b == "+") ||
               (b == "?") || (b == ">") || (b == "<") || (b == "/") || (b == ":") ||
               (b == "~") || f_is_alpha(b);
    endfunction

    function automatic logic f_is_sym_char(logic [7:0] b);
        return f_is_sym_start(b) || f_is_digit(b) || (b == CH_DOT) || (b == CH_MINUS);
    endfunction

    // A limit above the counter's range acts as the counter's largest value.
    function automatic t_lim f_clamp(logic [sts_pkg::CFG_W-1:0] lim);
        int v;
        v = int'(lim);
        if (v > LEN_MAX) begin
            v = LEN_MAX;
        end
        return t_lim'(v);
    endfunction

    function automatic t_scan f_emit(t_scan s, sts_pkg::t_kind k, logic [7:0] ch,
                                     sts_pkg::t_err e);
        t_scan r;
        r = s;
        if (r.cnt != 2'd3) begin
            r.res[r.cnt] = '{kind: k, chr: ch, err: e};
            r.cnt        = r.cnt + 2'd1;
        end
        return r;
    endfunction

    // An error drops input until end of input; an error on end of input closes at once.
    function automatic t_scan f_error(t_scan s, sts_pkg::t_err code, logic [7:0] b);
        t_scan r;
        r      = f_emit(s, sts_pkg::K_ERROR, CH_NUL, code);
        r.mode = M_ERROR;
        if (b == CH_NUL) begin
            r      = f_emit(r, sts_pkg::K_EOF, CH_NUL, sts_pkg::E_INVALID);
            r.mode = M_IDLE;
        end
        return r;
    endfunction

    function automatic t_scan f_sym_add(t_scan s, logic [7:0] b, t_lim lim);
        t_scan r;
        r = s;
        if ({1'b0, r.len} >= lim) begin
            r = f_error(r, sts_pkg::E_SYM_LONG, b);
        end else begin
            r.len  = r.len + 1'b1;
            r      = f_emit(r, sts_pkg::K_SYMCHAR, b, sts_pkg::E_INVALID);
            r.mode = M_SYMBOL;
        end
        return r;
    endfunction

    // The error path never closes the input here, so a nonzero byte is passed on.
    function automatic t_scan f_str_add(t_scan s, logic [7:0] ch, t_lim lim);
        t_scan r;
        r = s;
        if (({1'b0, r.len} + t_lim'(1)) >= lim) begin
            r = f_error(r, sts_pkg::E_STR_LONG, 8'h01);
        end else begin
            r.len  = r.len + 1'b1;
            r      = f_emit(r, sts_pkg::K_STRCHAR, ch, sts_pkg::E_INVALID);
            r.mode = M_STRING;
        end
        return r;
    endfunction

    function automatic t_scan f_idle(t_scan s, logic [7:0] b, t_lim slim);
        t_scan r;
        r      = s;
        r.mode = M_IDLE;
        if (b == CH_NUL) begin
            r = f_emit(r, sts_pkg::K_EOF, CH_NUL, sts_pkg::E_INVALID);
        end else if (f_is_space(b)) begin
            r.mode = M_IDLE;
        end else if (b == CH_SEMI) begin
            r.mode = M_COMMENT;
        end else if (b == CH_OPEN) begin
            r = f_emit(r, sts_pkg::K_OPEN, CH_NUL, sts_pkg::E_INVALID);
        end else if (b == CH_CLOSE) begin
            r = f_emit(r, sts_pkg::K_CLOSE, CH_NUL, sts_pkg::E_INVALID);
        end else if (b == CH_QUOTE) begin
            r = f_emit(r, sts_pkg::K_QUOTE, CH_NUL, sts_pkg::E_INVALID);
        end else if (b == CH_MINUS) begin
            r.mode = M_MINUS;
        end else if (b == CH_DOT) begin
            r.mode = M_DOT;
        end else if (b == CH_HASH) begin
            r.mode = M_HASH;
        end else if (f_is_digit(b)) begin
            r.acc  = t_val'(b - CH_0);
            r.neg  = 1'b0;
            r.base = BASE_10;
            r.mode = M_NUM;
        end else if (b == CH_DQUOT) begin
            r.len  = '0;
            r.mode = M_STRING;
        end else if (f_is_sym_start(b)) begin
            r.len = '0;
            r     = f_sym_add(r, b, slim);
        end else begin
            r = f_error(r, sts_pkg::E_INVALID, b);
        end
        return r;
    endfunction

    // One byte inside a number: a delimiter closes it, a valid digit does one multiply-add, any other byte is an error.
    function automatic t_scan f_num(t_scan s, logic [7:0] b, t_lim slim);
        t_scan      r;
        logic [5:0] d;
        logic       ok;
        r  = s;
        d  = '0;
        ok = 1'b1;
        if (f_is_space(b) || (b == CH_OPEN) || (b == CH_CLOSE) || (b == CH_NUL)) begin
            r.val = r.neg ? -r.acc : r.acc;
            r     = f_emit(r, sts_pkg::K_INT, CH_NUL, sts_pkg::E_INVALID);
            r     = f_idle(r, b, slim);
        end else begin
            if (f_is_digit(b)) begin
                d = 6'(b - CH_0);
            end else if ((b >= CH_LA) && (b <= CH_LZ)) begin
                d = 6'(b - CH_LA + 8'd10);
            end else if ((b >= CH_UA) && (b <= CH_UZ)) begin
                d = 6'(b - CH_UA + 8'd10);
            end else begin
                ok = 1'b0;
            end
            if (!ok || (d >= {1'b0, r.base})) begin
                r = f_error(r, sts_pkg::E_INVALID, b);
            end else begin
                r.acc  = (r.acc * t_val'(r.base)) + t_val'(d);
                r.mode = M_NUM;
            end
        end
        return r;
    endfunction

    // A pending minus or dot that turns out to open a symbol.
    function automatic t_scan f_lead(t_scan s, logic [7:0] lead, logic [7:0] b, t_lim slim);
        t_scan r;
        r     = s;
        r.len = '0;
        r     = f_sym_add(r, lead, slim);
        if (r.mode == M_SYMBOL) begin
            if (f_is_sym_char(b)) begin
                r = f_sym_add(r, b, slim);
            end else begin
                r = f_emit(r, sts_pkg::K_SYMEND, CH_NUL, sts_pkg::E_INVALID);
                r = f_idle(r, b, slim);
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] f_escape(logic [7:0] b);
        logic [7:0] c;
        c = b;
        if (b == "a") c = 8'd7;
        else if (b == "b") c = 8'd8;
        else if (b == "f") c = 8'd12;
        else if (b == "n") c = 8'd10;
        else if (b == "r") c = 8'd13;
        else if (b == "t") c = 8'd9;
        else if (b == "v") c = 8'd11;
        else if (b == CH_0) c = CH_NUL;
        return c;
    endfunction

    // Next state and results of the byte on the input.
    always_comb begin
        t_scan s;
        str_lim = f_clamp(i_string_limit);
        sym_lim = f_clamp(i_symbol_limit);
        s.mode  = r_mode;
        s.acc   = r_acc;
        s.neg   = r_neg;
        s.base  = r_base;
        s.len   = r_len;
        s.cnt   = '0;
        s.res   = '0;
        s.val   = '0;
        unique case (r_mode)
            M_COMMENT: begin
                if (i_byte == CH_NUL) begin
                    s      = f_emit(s, sts_pkg::K_EOF, CH_NUL, sts_pkg::E_INVALID);
                    s.mode = M_IDLE;
                end else if (i_byte == CH_LF) begin
                    s.mode = M_IDLE;
                end
            end
            M_MINUS: begin
                if (f_is_digit(i_byte)) begin
                    s.acc  = t_val'(i_byte - CH_0);
                    s.neg  = 1'b1;
                    s.base = BASE_10;
                    s.mode = M_NUM;
                end else begin
                    s = f_lead(s, CH_MINUS, i_byte, sym_lim);
                end
            end
            M_DOT: begin
                if (f_is_space(i_byte) || (i_byte == CH_NUL) || (i_byte == CH_CLOSE)) begin
                    s = f_emit(s, sts_pkg::K_DOT, CH_NUL, sts_pkg::E_INVALID);
                    s = f_idle(s, i_byte, sym_lim);
                end else begin
                    s = f_lead(s, CH_DOT, i_byte, sym_lim);
                end
            end
            M_HASH: begin
                if (i_byte == "t") begin
                    s      = f_emit(s, sts_pkg::K_TRUE, CH_NUL, sts_pkg::E_INVALID);
                    s.mode = M_IDLE;
                end else if (i_byte == "f") begin
                    s      = f_emit(s, sts_pkg::K_FALSE, CH_NUL, sts_pkg::E_INVALID);
                    s.mode = M_IDLE;
                end else if (i_byte == CH_BSL) begin
                    s = f_error(s, sts_pkg::E_CHAR_CONST, i_byte);
                end else if ((i_byte == "o") || (i_byte == "d") || (i_byte == "x")) begin
                    s.acc  = '0;
                    s.neg  = 1'b0;
                    s.base = (i_byte == "o") ? BASE_8 : ((i_byte == "d") ? BASE_10 : BASE_16);
                    s.mode = M_NUMSTART;
                end else begin
                    s = f_error(s, sts_pkg::E_INVALID, i_byte);
                end
            end
            M_NUMSTART: begin
                if (i_byte == CH_MINUS) begin
                    s.neg  = 1'b1;
                    s.mode = M_NUM;
                end else begin
                    s = f_num(s, i_byte, sym_lim);
                end
            end
            M_NUM: begin
                s = f_num(s, i_byte, sym_lim);
            end
            M_STRING: begin
                if (i_byte == CH_NUL) begin
                    s = f_error(s, sts_pkg::E_UNTERM, i_byte);
                end else if (i_byte == CH_DQUOT) begin
                    s      = f_emit(s, sts_pkg::K_STREND, CH_NUL, sts_pkg::E_INVALID);
                    s.mode = M_IDLE;
                end else if (i_byte == CH_BSL) begin
                    s.mode = M_STRESC;
                end else begin
                    s = f_str_add(s, i_byte, str_lim);
                end
            end
            M_STRESC: begin
                if (i_byte == CH_NUL) begin
                    s = f_error(s, sts_pkg::E_UNTERM, i_byte);
                end else begin
                    s = f_str_add(s, f_escape(i_byte), str_lim);
                end
            end
            M_SYMBOL: begin
                if (f_is_sym_char(i_byte)) begin
                    s = f_sym_add(s, i_byte, sym_lim);
                end else begin
                    s = f_emit(s, sts_pkg::K_SYMEND, CH_NUL, sts_pkg::E_INVALID);
                    s = f_idle(s, i_byte, sym_lim);
                end
            end
            M_ERROR: begin
                if (i_byte == CH_NUL) begin
                    s      = f_emit(s, sts_pkg::K_EOF, CH_NUL, sts_pkg::E_INVALID);
                    s.mode = M_IDLE;
                end
            end
            M_IDLE: begin
                s = f_idle(s, i_byte, sym_lim);
            end
            default: begin
                s = f_idle(s, i_byte, sym_lim);
            end
        endcase
        s_nxt = s;
    end

    // Scanner state advances on every accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_acc  <= '0;
            r_neg  <= 1'b0;
            r_base <= BASE_10;
            r_len  <= '0;
        end else if (i_accept) begin
            r_mode <= s_nxt.mode;
            r_acc  <= s_nxt.acc;
            r_neg  <= s_nxt.neg;
            r_base <= s_nxt.base;
            r_len  <= s_nxt.len;
        end
    end

    // Items that cause at least one result go to the queue as one entry.
    assign o_enq   = i_accept && (s_nxt.cnt != 2'd0);
    assign o_cnt   = s_nxt.cnt;
    assign o_slots = s_nxt.res;
    assign o_val   = s_nxt.val;

endmodule

// ----- rtl/sts_queue.sv -----
module sts_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_full,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_head;
    logic [AW-1:0]    r_tail;
    logic [CW-1:0]    r_count;
    logic             wr_en;
    logic             rd_en;

    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_head];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_tail] <= i_wdata;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_tail <= (r_tail == LAST) ? '0 : r_tail + 1'b1;
            end
            if (rd_en) begin
                r_head <= (r_head == LAST) ? '0 : r_head + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/sts_back.sv -----
module sts_back #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_empty,
    input  sts_pkg::t_count               i_cnt,
    input  sts_pkg::t_slot [2:0]          i_slots,
    input  logic [VALUE_WIDTH-1:0]        i_val,
    output logic                          o_deq,
    input  logic                          i_pop,
    output logic                          o_empty,
    output logic [3:0]                    o_token_kind,
    output logic signed [VALUE_WIDTH-1:0] o_int_value,
    output logic [7:0]                    o_char_byte,
    output logic [2:0]                    o_error_code,
    output logic                          o_last_of_byte
);

    logic                   r_out_vld;
    sts_pkg::t_count        r_idx;
    sts_pkg::t_slot         r_slot;
    logic [VALUE_WIDTH-1:0] r_val;
    logic                   r_last;

    sts_pkg::t_slot         cur;
    logic                   take;
    logic                   is_last;

    // The output register refills from the queue whenever it is empty or being drained and the queue holds an entry.
    assign cur     = i_slots[r_idx];
    assign take    = !i_q_empty && (!r_out_vld || i_pop);
    assign is_last = (r_idx == (i_cnt - 2'd1));
    assign o_deq   = take && is_last;

    // Walk the results of the head entry, one per cycle while the output is empty or being popped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_idx     <= '0;
        end else begin
            if (take) begin
                r_out_vld <= 1'b1;
                r_idx     <= is_last ? '0 : r_idx + 2'd1;
            end else if (i_pop) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_slot <= cur;
            r_val  <= (cur.kind == sts_pkg::K_INT) ? i_val : '0;
            r_last <= is_last;
        end
    end

    assign o_empty        = !r_out_vld;
    assign o_token_kind   = r_slot.kind;
    assign o_int_value    = r_val;
    assign o_char_byte    = r_slot.chr;
    assign o_error_code   = r_slot.err;
    assign o_last_of_byte = r_last;

endmodule

// ----- rtl/sexpr_token_scanner.sv -----
// The first result of a byte is written into the queue when the byte is taken, and is then
// registered in the output register, where it reaches the result ports and can be popped.
// Throughput: one byte per cycle in while the queue is not full; one result per cycle out while
// results are popped. A four-entry queue between scanner and output absorbs bursts.
// Reset is synchronous and active low: the scanner returns to idle, the queue and the output
// register empty, and both length limits return to 255.
module sexpr_token_scanner #(
    parameter int VALUE_WIDTH  = 32,
    parameter int LENGTH_WIDTH = 12
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic [7:0]                         i_source_byte,
    output logic                               empty,
    input  logic                               pop,
    output logic [3:0]                         o_token_kind,
    output logic signed [VALUE_WIDTH-1:0]      o_int_value,
    output logic [7:0]                         o_char_byte,
    output logic [2:0]                         o_error_code,
    output logic                               o_last_of_byte,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sts_pkg::ADDR_W-1:0]         paddr,
    input  logic [sts_pkg::APB_W-1:0]          pwdata,
    output logic [sts_pkg::APB_W-1:0]          prdata,
    output logic                               pready
);

    localparam int SLOT_W   = $bits(sts_pkg::t_slot);
    localparam int SLOTS_W  = sts_pkg::SLOTS * SLOT_W;
    localparam int BUNDLE_W = 2 + SLOTS_W + VALUE_WIDTH;

    logic [sts_pkg::CFG_W-1:0] r_string_limit;
    logic [sts_pkg::CFG_W-1:0] r_symbol_limit;

    logic                      accept;
    logic                      enq;
    sts_pkg::t_count           enq_cnt;
    sts_pkg::t_slot [2:0]      enq_slots;
    logic [VALUE_WIDTH-1:0]    enq_val;
    logic [BUNDLE_W-1:0]       q_wdata;
    logic [BUNDLE_W-1:0]       q_rdata;
    logic                      q_empty;
    logic                      q_rd;
    logic                      cfg_wr;

    // Configuration registers, one word each.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_string_limit <= sts_pkg::LIMIT_RESET;
            r_symbol_limit <= sts_pkg::LIMIT_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == sts_pkg::REG_STRING_LIMIT) begin
                r_string_limit <= pwdata[sts_pkg::CFG_W-1:0];
            end else begin
                r_symbol_limit <= pwdata[sts_pkg::CFG_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == sts_pkg::REG_STRING_LIMIT) begin
            prdata = {{(sts_pkg::APB_W - sts_pkg::CFG_W){1'b0}}, r_string_limit};
        end else begin
            prdata = {{(sts_pkg::APB_W - sts_pkg::CFG_W){1'b0}}, r_symbol_limit};
        end
    end

    // Front end: scanner state machine.
    assign accept = push && !full;

    sts_front #(
        .VALUE_WIDTH  (VALUE_WIDTH),
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_byte         (i_source_byte),
        .i_string_limit (r_string_limit),
        .i_symbol_limit (r_symbol_limit),
        .o_enq          (enq),
        .o_cnt          (enq_cnt),
        .o_slots        (enq_slots),
        .o_val          (enq_val)
    );

    // Queue of per-byte result groups.
    assign q_wdata = {enq_cnt, enq_slots, enq_val};

    sts_queue #(
        .WIDTH (BUNDLE_W),
        .DEPTH (sts_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (enq),
        .i_wdata (q_wdata),
        .i_rd    (q_rd),
        .o_rdata (q_rdata),
        .o_full  (full),
        .o_empty (q_empty)
    );

    // Back end: serializes results onto the output.
    sts_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_cnt          (q_rdata[BUNDLE_W-1 -: 2]),
        .i_slots        (q_rdata[VALUE_WIDTH +: SLOTS_W]),
        .i_val          (q_rdata[VALUE_WIDTH-1:0]),
        .o_deq          (q_rd),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_token_kind   (o_token_kind),
        .o_int_value    (o_int_value),
        .o_char_byte    (o_char_byte),
        .o_error_code   (o_error_code),
        .o_last_of_byte (o_last_of_byte)
    );

endmodule

// ----- rtl/sts_checker.sv -----
module sts_checker #(
    parameter int VALUE_WIDTH = 32
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          empty,
    input logic                          pop,
    input logic [3:0]                    o_token_kind,
    input logic signed [VALUE_WIDTH-1:0] o_int_value,
    input logic [7:0]                    o_char_byte,
    input logic [2:0]                    o_error_code,
    input logic                          o_last_of_byte
);

    // Reset leaves no result waiting.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result waiting after reset");

    // End of input is always the final result of its byte.
    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_token_kind == sts_pkg::K_EOF)) |-> o_last_of_byte)
        else $error("eof token not marked last of byte");

    // Only integer tokens carry a value.
    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_token_kind != sts_pkg::K_INT)) |-> (o_int_value == '0))
        else $error("value on a token that is not an integer");

    // Only error tokens carry an error code.
    a_code_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_token_kind != sts_pkg::K_ERROR)) |-> (o_error_code == '0))
        else $error("error code on a token that is not an error");

    // A stalled result stays in place.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_token_kind) && $stable(o_char_byte)
                              && $stable(o_last_of_byte)))
        else $error("waiting result changed while stalled");

endmodule

bind sexpr_token_scanner sts_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_sts_checker (.*);
